### rtl/core/brle_pkg.sv
package brle_pkg;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_HEAD   = 5'b00001,
        ST_BLOCK  = 5'b00010,
        ST_LIT    = 5'b00100,
        ST_RUNVAL = 5'b01000,
        ST_RUN    = 5'b10000
    } state_t;

    // Result status codes.
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_TAG_BAD  = 2'd1;
    localparam logic [1:0] STS_ZERO_LEN = 2'd2;

    localparam logic [7:0] TAG_RESET = 8'd48;
    localparam int         RUN_FLAG_BIT = 7;
    localparam logic [7:0] RUN_BIAS = 8'd3;
    localparam logic [7:0] LIT_BIAS = 8'd1;
    localparam logic [1:0] HDR_LAST_IDX = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hdr_step;
        logic blk_load;
        logic lit_push;
        logic run_load;
        logic run_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hdr_final;
        logic hdr_err;
        logic blk_is_run;
        logic stream_end;
        logic blk_end;
        logic out_free;
    } sts_t;

endpackage

### rtl/core/byte_rle_decompressor.sv
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] in_byte
// m_axis    out        tdata: out_data, byte_count, zero fill; tlast last_of_run;
//                      tuser: stream_done, status
// cfg       in         cfg_data[7:0] expected_tag
//
// Header, block and literal bytes are taken one at a time, while the result register is free.
// A run value byte is taken, then the input is held while the run writes its output
// words, each filled with as many run bytes as its free lanes allow; the single
// result register sets that pace, since a run word is built only when that register is free.
// Reset is asynchronous; expected_tag resets to 48 and the block waits for a header.
// A stall on m_axis holds the result register and, through it, the input side.
module byte_rle_decompressor #(
    parameter int LENGTH_BITS = 24,
    parameter int OUT_LANES   = 4,
    localparam int DW     = 8 * OUT_LANES,
    localparam int CW     = $clog2(OUT_LANES + 1),
    localparam int OTD_W  = ((DW + CW + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] in_byte

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OTD_W-1:0] m_axis_tdata,   // out_data, then byte_count, then zero fill
    output logic             m_axis_tlast,
    output logic [2:0]       m_axis_tuser,   // [0] stream_done, [2:1] status

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data        // [7:0] expected_tag
);

    brle_pkg::cmd_t cmd;
    brle_pkg::sts_t sts;
    logic [DW-1:0]  out_data;
    logic [CW-1:0]  byte_count;
    logic           stream_done;
    logic [1:0]     status;

    assign cfg_ready = 1'b1;

    brle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    brle_dpath #(
        .LENGTH_BITS (LENGTH_BITS),
        .OUT_LANES   (OUT_LANES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_tag     (cfg_data),
        .in_byte     (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (out_data),
        .byte_count  (byte_count),
        .last_of_run (m_axis_tlast),
        .stream_done (stream_done),
        .status      (status)
    );

    assign m_axis_tdata = {{(OTD_W - DW - CW){1'b0}}, byte_count, out_data};
    assign m_axis_tuser = {status, stream_done};

endmodule

### rtl/core/brle_ctrl.sv
module brle_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  brle_pkg::sts_t sts,
    output brle_pkg::cmd_t cmd
);

    brle_pkg::state_t state_reg;
    brle_pkg::state_t state_next;
    logic             fire;

    assign in_ready = sts.out_free && (state_reg != brle_pkg::ST_RUN);
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.hdr_step = fire && (state_reg == brle_pkg::ST_HEAD);
        cmd.blk_load = fire && (state_reg == brle_pkg::ST_BLOCK);
        cmd.lit_push = fire && (state_reg == brle_pkg::ST_LIT);
        cmd.run_load = fire && (state_reg == brle_pkg::ST_RUNVAL);
        cmd.run_step = sts.out_free && (state_reg == brle_pkg::ST_RUN);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brle_pkg::ST_HEAD:
            begin
                if (fire && sts.hdr_final && !sts.hdr_err)
                begin
                    state_next = brle_pkg::ST_BLOCK;
                end
            end
            brle_pkg::ST_BLOCK:
            begin
                if (fire)
                begin
                    state_next = sts.blk_is_run ? brle_pkg::ST_RUNVAL : brle_pkg::ST_LIT;
                end
            end
            brle_pkg::ST_LIT:
            begin
                if (fire)
                begin
                    if (sts.stream_end)
                    begin
                        state_next = brle_pkg::ST_HEAD;
                    end
                    else if (sts.blk_end)
                    begin
                        state_next = brle_pkg::ST_BLOCK;
                    end
                end
            end
            brle_pkg::ST_RUNVAL:
            begin
                if (fire)
                begin
                    state_next = brle_pkg::ST_RUN;
                end
            end
            brle_pkg::ST_RUN:
            begin
                // The run leaves once its last bytes have gone into the word.
                if (sts.out_free && sts.blk_end)
                begin
                    state_next = sts.stream_end ? brle_pkg::ST_HEAD : brle_pkg::ST_BLOCK;
                end
            end
            default:
            begin
                state_next = brle_pkg::ST_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brle_pkg::ST_HEAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/brle_dpath.sv
module brle_dpath #(
    parameter int LENGTH_BITS = 24,
    parameter int OUT_LANES   = 4,
    localparam int DW = 8 * OUT_LANES,
    localparam int CW = $clog2(OUT_LANES + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [7:0]     cfg_tag,
    input  logic [7:0]     in_byte,
    input  brle_pkg::cmd_t cmd,
    output brle_pkg::sts_t sts,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [DW-1:0]  out_data,
    output logic [CW-1:0]  byte_count,
    output logic           last_of_run,
    output logic           stream_done,
    output logic [1:0]     status
);

    localparam int LW = LENGTH_BITS;

    logic [7:0]    tag_reg;
    logic [1:0]    hdr_idx_reg;
    logic [7:0]    hdr_tag_reg;
    logic [15:0]   hdr_len_reg;
    logic [LW-1:0] bytes_rem_reg;
    logic [7:0]    blk_rem_reg;
    logic [7:0]    run_val_reg;
    logic [DW-1:0] pack_reg;
    logic [CW-1:0] fill_reg;

    logic          out_valid_reg;
    logic [DW-1:0] out_data_reg;
    logic [CW-1:0] out_count_reg;
    logic          out_last_reg;
    logic          out_done_reg;
    logic [1:0]    out_status_reg;

    logic [23:0]   hdr_full;
    logic [LW-1:0] hdr_len;
    logic          tag_bad;
    logic          len_zero;
    logic [7:0]    blk_raw;
    logic [7:0]    blk_clip;
    logic [CW-1:0] space;
    logic [CW-1:0] run_n;
    logic [CW-1:0] push_n;
    logic [7:0]    push_val;
    logic          push;
    logic [CW-1:0] new_fill;
    logic          word_full;
    logic          stream_end;
    logic          blk_end;
    logic [7:0]    blk_left;
    logic          run_last;
    logic          emit_word;
    logic          emit_err;
    logic          out_free;
    logic [DW-1:0] word_cmb;

    assign out_free = !out_valid_reg || out_ready;

    // Header decode.
    assign hdr_full = {in_byte, hdr_len_reg};
    assign hdr_len  = hdr_full[LW-1:0];
    assign tag_bad  = hdr_tag_reg != tag_reg;
    assign len_zero = hdr_len == '0;
    assign emit_err = cmd.hdr_step && (hdr_idx_reg == brle_pkg::HDR_LAST_IDX)
                      && (tag_bad || len_zero);

    // Block length, clipped to the bytes still owed.
    assign blk_raw  = in_byte[brle_pkg::RUN_FLAG_BIT]
                      ? ({1'b0, in_byte[6:0]} + brle_pkg::RUN_BIAS)
                      : (in_byte + brle_pkg::LIT_BIAS);
    assign blk_clip = (bytes_rem_reg < LW'(blk_raw)) ? bytes_rem_reg[7:0] : blk_raw;

    // A run fills as many free lanes of the current word as it can per cycle while the result register is free.
    assign space    = CW'(OUT_LANES) - fill_reg;
    assign run_n    = (blk_rem_reg < 8'(space)) ? blk_rem_reg[CW-1:0] : space;
    assign push     = cmd.lit_push || cmd.run_step;
    assign push_n   = cmd.lit_push ? CW'(1) : run_n;
    assign push_val = cmd.lit_push ? in_byte : run_val_reg;

    assign new_fill   = fill_reg + push_n;
    assign word_full  = new_fill == CW'(OUT_LANES);
    assign stream_end = bytes_rem_reg == LW'(push_n);
    assign blk_end    = blk_rem_reg == 8'(push_n);
    assign blk_left   = blk_rem_reg - 8'(push_n);
    assign emit_word  = push && (word_full || stream_end);

    // A run word is the last result of the run when nothing follows it: the
    // block ends here, or what is left cannot fill a word and does not end the
    // stream.
    assign run_last = blk_end || ((blk_left < 8'(OUT_LANES))
                      && (LW'(blk_rem_reg) != bytes_rem_reg));

    always_comb
    begin
        word_cmb = pack_reg;
        for (int i = 0; i < OUT_LANES; i++)
        begin
            if (push && ((CW+1)'(i) >= {1'b0, fill_reg})
                && ((CW+1)'(i) < ({1'b0, fill_reg} + {1'b0, push_n})))
            begin
                word_cmb[8*i +: 8] = push_val;
            end
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.hdr_final  = hdr_idx_reg == brle_pkg::HDR_LAST_IDX;
        sts.hdr_err    = tag_bad || len_zero;
        sts.blk_is_run = in_byte[brle_pkg::RUN_FLAG_BIT];
        sts.stream_end = stream_end;
        sts.blk_end    = blk_end;
        sts.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg       <= brle_pkg::TAG_RESET;
            hdr_idx_reg   <= '0;
            hdr_tag_reg   <= '0;
            hdr_len_reg   <= '0;
            bytes_rem_reg <= '0;
            blk_rem_reg   <= '0;
            run_val_reg   <= '0;
            pack_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                tag_reg <= cfg_tag;
            end

            if (cmd.hdr_step)
            begin
                hdr_idx_reg <= hdr_idx_reg + 2'd1;
                case (hdr_idx_reg)
                    2'd0:
                    begin
                        hdr_tag_reg <= in_byte;
                    end
                    2'd1:
                    begin
                        hdr_len_reg[7:0] <= in_byte;
                    end
                    2'd2:
                    begin
                        hdr_len_reg[15:8] <= in_byte;
                    end
                    default:
                    begin
                        bytes_rem_reg <= hdr_len;
                        blk_rem_reg   <= '0;
                        pack_reg      <= '0;
                        fill_reg      <= '0;
                    end
                endcase
            end

            if (cmd.blk_load)
            begin
                blk_rem_reg <= blk_clip;
            end

            if (cmd.run_load)
            begin
                run_val_reg <= in_byte;
            end

            if (push)
            begin
                bytes_rem_reg <= bytes_rem_reg - LW'(push_n);
                blk_rem_reg   <= blk_left;
                if (emit_word)
                begin
                    pack_reg <= '0;
                    fill_reg <= '0;
                end
                else
                begin
                    pack_reg <= word_cmb;
                    fill_reg <= new_fill;
                end
            end

            if (emit_word || emit_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_err)
        begin
            out_data_reg   <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b1;
            out_done_reg   <= 1'b0;
            out_status_reg <= tag_bad ? brle_pkg::STS_TAG_BAD : brle_pkg::STS_ZERO_LEN;
        end
        else if (emit_word)
        begin
            out_data_reg   <= word_cmb;
            out_count_reg  <= new_fill;
            out_last_reg   <= cmd.lit_push || run_last;
            out_done_reg   <= stream_end;
            out_status_reg <= brle_pkg::STS_OK;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign byte_count  = out_count_reg;
    assign last_of_run = out_last_reg;
    assign stream_done = out_done_reg;
    assign status      = out_status_reg;

endmodule

### dv/tb_byte_rle_decompressor.sv
module tb_byte_rle_decompressor;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_BLOCK,
        DEC_RUN_VALUE,
        DEC_LITERAL
    } dec_phase_t;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
        logic        done;
        logic [1:0]  status;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;

    // Stimulus and expectations.
    logic [7:0]  compressed_q[$];
    out_word_t   decoded_word_q[$];
    int          sent_items = 0;
    int          expected_word_count = 0;
    int          error_count = 0;

    // Traffic shaping.
    bit          steady_flow = 1'b0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;

    // Decoder shadow state.
    logic [7:0]  tag_shadow = brle_pkg::TAG_RESET;
    dec_phase_t  dec_phase = DEC_HEADER;
    int          hdr_idx = 0;
    logic [7:0]  hdr_tag = 8'h00;
    logic [23:0] owed = '0;
    int          blk_left = 0;
    logic [31:0] word_buf = '0;
    int          word_fill = 0;

    byte_rle_decompressor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void push_word(input logic [31:0] data, input logic [2:0] count,
                                      input logic [1:0] status);
        decoded_word_q.push_back('{data, count, 1'b0, 1'b0, status});
        expected_word_count++;
    endfunction

    function automatic void store_lane(input logic [7:0] b);
        word_buf[8*word_fill +: 8] = b;
        word_fill++;
        owed--;
        blk_left--;
        if (word_fill == 4)
        begin
            push_word(word_buf, 3'd4, brle_pkg::STS_OK);
            word_buf = '0;
            word_fill = 0;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int n_before;
        int span;
        bit was_data;
        n_before = decoded_word_q.size();
        was_data = (dec_phase == DEC_RUN_VALUE) || (dec_phase == DEC_LITERAL);
        case (dec_phase)
            DEC_HEADER:
            begin
                if (hdr_idx == 0)
                begin
                    hdr_tag = b;
                    owed = '0;
                    hdr_idx = 1;
                end
                else
                begin
                    owed[8*(hdr_idx-1) +: 8] = b;
                    if (hdr_idx < 3)
                        hdr_idx++;
                    else
                    begin
                        hdr_idx = 0;
                        word_buf = '0;
                        word_fill = 0;
                        blk_left = 0;
                        // The tag is checked ahead of the length.
                        if (hdr_tag != tag_shadow || owed == 0)
                        begin
                            push_word('0, 3'd0,
                                      (hdr_tag != tag_shadow) ? brle_pkg::STS_TAG_BAD
                                                              : brle_pkg::STS_ZERO_LEN);
                            owed = '0;
                        end
                        else
                            dec_phase = DEC_BLOCK;
                    end
                end
            end
            DEC_BLOCK:
            begin
                span = b[brle_pkg::RUN_FLAG_BIT] ? int'(b[6:0]) + int'(brle_pkg::RUN_BIAS)
                                                 : int'(b) + int'(brle_pkg::LIT_BIAS);
                blk_left = (span < int'(owed)) ? span : int'(owed);
                dec_phase = b[brle_pkg::RUN_FLAG_BIT] ? DEC_RUN_VALUE : DEC_LITERAL;
            end
            DEC_RUN_VALUE:
            begin
                while (blk_left > 0 && owed != 0)
                    store_lane(b);
                dec_phase = DEC_BLOCK;
            end
            DEC_LITERAL:
            begin
                if (blk_left > 0 && owed != 0)
                    store_lane(b);
                if (blk_left == 0)
                    dec_phase = DEC_BLOCK;
            end
        endcase
        // Reaching the declared length flushes any partial word and drops
        // whatever is left of the current block.
        if (was_data && owed == 0)
        begin
            if (word_fill > 0)
                push_word(word_buf, 3'(word_fill), brle_pkg::STS_OK);
            word_buf = '0;
            word_fill = 0;
            if (decoded_word_q.size() > n_before)
                decoded_word_q[decoded_word_q.size()-1].done = 1'b1;
            dec_phase = DEC_HEADER;
            hdr_idx = 0;
            blk_left = 0;
        end
        if (decoded_word_q.size() > n_before)
            decoded_word_q[decoded_word_q.size()-1].last = 1'b1;
    endfunction

    function automatic void send_byte(input logic [7:0] b);
        compressed_q.push_back(b);
        decode_byte(b);
        sent_items++;
    endfunction

    function automatic void send_header(input logic [7:0] tag, input logic [23:0] len);
        send_byte(tag);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(len[23:16]);
    endfunction

    function automatic void send_stream(input int len);
        int owed_left;
        int cnt;
        int take;
        logic [7:0] blk;
        send_header(tag_shadow, 24'(len));
        owed_left = len;
        while (owed_left > 0)
        begin
            cnt = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 127);
            blk = cnt[7:0];
            if ($urandom_range(0, 1) == 1)
            begin
                blk[brle_pkg::RUN_FLAG_BIT] = 1'b1;
                send_byte(blk);
                send_byte(8'($urandom));
                take = cnt + int'(brle_pkg::RUN_BIAS);
            end
            else
            begin
                send_byte(blk);
                take = cnt + int'(brle_pkg::LIT_BIAS);
                if (take > owed_left)
                    take = owed_left;
                repeat (take)
                    send_byte(8'($urandom));
            end
            owed_left -= (take < owed_left) ? take : owed_left;
        end
    endfunction

    // Broken headers and junk; no header with a matching tag and a nonzero length is let through here, so the
    // decoder always ends up back at the start of a header.
    function automatic void send_noise();
        int n;
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: send_header(tag_shadow ^ (8'h01 << $urandom_range(0, 7)), 24'($urandom));
            1: send_header(tag_shadow, 24'd0);
            default:
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    b = 8'($urandom);
                    if (dec_phase == DEC_HEADER && hdr_idx == 0 && b == tag_shadow)
                        b ^= 8'h01;
                    send_byte(b);
                end
            end
        endcase
        while (hdr_idx != 0)
            send_byte(8'($urandom));
    endfunction

    task automatic wait_drained();
        while (compressed_q.size() != 0 || s_axis_tvalid || decoded_word_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_tag(input logic [7:0] v);
        @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        tag_shadow = v;
    endtask

    // Byte source.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (compressed_q.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 15))
            begin
                s_axis_tdata <= compressed_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result sink, with an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge clk)
    begin : result_check
        out_word_t got;
        out_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast,
                    m_axis_tuser[0], m_axis_tuser[2:1]};
            if (decoded_word_q.size() == 0)
            begin
                $error("unexpected result request: out_data %h byte_count %0d",
                       got.data, got.count);
                error_count++;
            end
            else
            begin
                want = decoded_word_q.pop_front();
                if (got.data !== want.data)
                begin
                    $error("out_data mismatch: expected %h, actual %h", want.data, got.data);
                    error_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("byte_count mismatch: expected %0d, actual %0d",
                           want.count, got.count);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_of_run mismatch: expected %b, actual %b", want.last, got.last);
                    error_count++;
                end
                if (got.done !== want.done)
                begin
                    $error("stream_done mismatch: expected %b, actual %b", want.done, got.done);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int phase_no;
        int start_items;
        int len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Longest run, shortest run, literal block clipped to the
        // tail of the stream, then the two header errors.
        send_header(brle_pkg::TAG_RESET, 24'd140);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h3C);
        send_header(8'h31, 24'hFFFFFF);
        send_header(brle_pkg::TAG_RESET, 24'd0);
        wait_drained();

        for (phase_no = 0; sent_items < 420 || expected_word_count < 80; phase_no++)
        begin
            case (phase_no)
                0: write_tag(8'h00);
                1: write_tag(8'hFF);
                default: write_tag(8'($urandom));
            endcase
            steady_flow = (phase_no == 0);
            start_items = sent_items;
            while (sent_items - start_items < 100)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                                        : $urandom_range(41, 300);
                    send_stream(len);
                end
                else
                    send_noise();
            end
            if (phase_no == 1 || phase_no == 3)
                hold_req++;
            wait_drained();
            steady_flow = 1'b0;
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
